/* sv/finder_rectangle_box_corners_top_defines.svh */
// Assertion macros shared by the box corner finder RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef FINDER_RECTANGLE_BOX_CORNERS_TOP_DEFINES_SVH
`define FINDER_RECTANGLE_BOX_CORNERS_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define FRBC_ASSERT_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FRBC_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/frbc_pkg.sv */
// Shared types and constants of the box corner finder.
// Used by frbc_edge and finder_rectangle_box_corners_top; no dependencies.
package frbc_pkg;

  localparam int UNIT_SHIFT = 15;
  localparam int QUARTERS   = 4;
  localparam int MODULES    = 7;
  localparam int DIV_STEPS  = 31;
  localparam int SQRT_STEPS = 16;
  // Cycles from the edge inputs to the registered unit vector.
  localparam int EDGE_LAT   = 3 + DIV_STEPS + SQRT_STEPS + 1;
  localparam logic [4:0] MO_RESET = 5'd16;

  typedef struct packed {
    logic signed [16:0] ux;
    logic signed [16:0] uy;
    logic               deg;
  } frbc_unit_t;

endpackage

/* sv/frbc_edge.sv */
// Pipelined Q1.15 unit vector from point b toward point a.
// Depends on frbc_pkg; squares, restoring divider and integer root stages.
module frbc_edge import frbc_pkg::*; #(
  parameter int IN_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic [IN_BITS-1:0] a_x,
  input  logic [IN_BITS-1:0] a_y,
  input  logic [IN_BITS-1:0] b_x,
  input  logic [IN_BITS-1:0] b_y,
  output frbc_unit_t         unit
);

  localparam int WX  = (IN_BITS > 16) ? IN_BITS : 16;
  localparam int NSH = (IN_BITS > 16) ? IN_BITS - 16 : 0;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic zero;
  } side_t;

  logic signed [IN_BITS:0] dx, dy;
  logic [IN_BITS-1:0] adx, ady;
  logic [WX-1:0] wx, wy, orv;
  logic [15:0] mx16, my16;

  assign dx  = $signed({1'b0, a_x}) - $signed({1'b0, b_x});
  assign dy  = $signed({1'b0, a_y}) - $signed({1'b0, b_y});
  assign adx = dx[IN_BITS] ? IN_BITS'(-dx) : dx[IN_BITS-1:0];
  assign ady = dy[IN_BITS] ? IN_BITS'(-dy) : dy[IN_BITS-1:0];
  assign wx  = WX'(adx);
  assign wy  = WX'(ady);
  assign orv = wx | wy;

  // Wide coordinates: shift both magnitudes by the least amount that brings
  // them below 2^16.
  always_comb begin
    mx16 = 16'(wx >> NSH);
    my16 = 16'(wy >> NSH);
    for (int k = NSH - 1; k >= 0; k--) begin
      if (((orv >> k) >> 16) == '0) begin
        mx16 = 16'(wx >> k);
        my16 = 16'(wy >> k);
      end
    end
  end

  logic [15:0] mx, my;
  side_t sd1, sd2;
  logic [31:0] sqx, sqy;

  always_ff @(posedge clk) begin
    if (en) begin
      mx  <= mx16;
      my  <= my16;
      sd1 <= '{neg_x: dx[IN_BITS], neg_y: dy[IN_BITS], zero: ((mx16 | my16) == '0)};
      sqx <= 32'(mx) * 32'(mx);
      sqy <= 32'(my) * 32'(my);
      sd2 <= sd1;
    end
  end

  // Divider: quotient of sq * 2^30 by the squared length, one bit a stage.
  logic [32:0] dv_s  [DIV_STEPS+1];
  logic [33:0] dv_rx [DIV_STEPS+1];
  logic [33:0] dv_ry [DIV_STEPS+1];
  logic [30:0] dv_qx [DIV_STEPS+1];
  logic [30:0] dv_qy [DIV_STEPS+1];
  side_t       dv_sd [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_s[0]  <= {1'b0, sqx} + {1'b0, sqy};
      dv_rx[0] <= 34'(sqx);
      dv_ry[0] <= 34'(sqy);
      dv_qx[0] <= '0;
      dv_qy[0] <= '0;
      dv_sd[0] <= sd2;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [33:0] tx, ty;
    assign tx = (k == 0) ? dv_rx[k] : {dv_rx[k][32:0], 1'b0};
    assign ty = (k == 0) ? dv_ry[k] : {dv_ry[k][32:0], 1'b0};
    always_ff @(posedge clk) begin
      if (en) begin
        dv_s[k+1]  <= dv_s[k];
        dv_sd[k+1] <= dv_sd[k];
        if (tx >= {1'b0, dv_s[k]}) begin
          dv_rx[k+1] <= tx - {1'b0, dv_s[k]};
          dv_qx[k+1] <= dv_qx[k] | (31'd1 << (DIV_STEPS - 1 - k));
        end else begin
          dv_rx[k+1] <= tx;
          dv_qx[k+1] <= dv_qx[k];
        end
        if (ty >= {1'b0, dv_s[k]}) begin
          dv_ry[k+1] <= ty - {1'b0, dv_s[k]};
          dv_qy[k+1] <= dv_qy[k] | (31'd1 << (DIV_STEPS - 1 - k));
        end else begin
          dv_ry[k+1] <= ty;
          dv_qy[k+1] <= dv_qy[k];
        end
      end
    end
  end

  // Integer square root, two radicand bits a stage.
  logic [31:0] sq_vx [SQRT_STEPS+1];
  logic [31:0] sq_vy [SQRT_STEPS+1];
  logic [31:0] sq_rx [SQRT_STEPS+1];
  logic [31:0] sq_ry [SQRT_STEPS+1];
  side_t       sq_sd [SQRT_STEPS+1];

  assign sq_vx[0] = 32'(dv_qx[DIV_STEPS]);
  assign sq_vy[0] = 32'(dv_qy[DIV_STEPS]);
  assign sq_rx[0] = '0;
  assign sq_ry[0] = '0;
  assign sq_sd[0] = dv_sd[DIV_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [31:0] BIT = 32'd1 << (30 - 2 * j);
    logic [31:0] cx, cy;
    assign cx = sq_rx[j] + BIT;
    assign cy = sq_ry[j] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        sq_sd[j+1] <= sq_sd[j];
        if (sq_vx[j] >= cx) begin
          sq_vx[j+1] <= sq_vx[j] - cx;
          sq_rx[j+1] <= (sq_rx[j] >> 1) + BIT;
        end else begin
          sq_vx[j+1] <= sq_vx[j];
          sq_rx[j+1] <= sq_rx[j] >> 1;
        end
        if (sq_vy[j] >= cy) begin
          sq_vy[j+1] <= sq_vy[j] - cy;
          sq_ry[j+1] <= (sq_ry[j] >> 1) + BIT;
        end else begin
          sq_vy[j+1] <= sq_vy[j];
          sq_ry[j+1] <= sq_ry[j] >> 1;
        end
      end
    end
  end

  logic signed [16:0] rx17, ry17;
  side_t sdf;
  assign rx17 = $signed(17'(sq_rx[SQRT_STEPS]));
  assign ry17 = $signed(17'(sq_ry[SQRT_STEPS]));
  assign sdf  = sq_sd[SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      unit.deg <= sdf.zero;
      unit.ux  <= sdf.zero ? '0 : (sdf.neg_x ? -rx17 : rx17);
      unit.uy  <= sdf.zero ? '0 : (sdf.neg_y ? -ry17 : ry17);
    end
  end

endmodule

/* sv/finder_rectangle_box_corners_top.sv */
// Box corners for a rectangle of four finder markers, fully pipelined.
// Depends on frbc_pkg, frbc_edge and finder_rectangle_box_corners_top_defines.svh.
//
// Usage:
//   s_axis carries one word: centres A..D in ring order, each x, y and width.
//   m_axis returns one word per input word: the four box corners, with the
//   degenerate flag in m_axis_tuser (set when two ring neighbours coincide).
//   cfg_we/cfg_wdata write module_offset (quarter modules); write it only
//   while no word is in flight.
// Pipeline: an accepted word reaches m_axis_tvalid through the 31-stage
//   restoring divider and the 16-stage square root in each edge unit plus
//   the scaling and saturation stages.
// Throughput: one word per cycle. All stages advance together; while the
//   output word waits for m_axis_tready the whole pipeline holds, and
//   s_axis_tready is low only then.
// Reset: rst clears every valid bit and loads module_offset with 16.
`include "finder_rectangle_box_corners_top_defines.svh"
module finder_rectangle_box_corners_top import frbc_pkg::*; #(
  parameter int COORD_INT_BITS = 12,
  parameter int FRAC_BITS      = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // a_x, a_y, a_width, b_x, b_y, b_width, c_x, c_y, c_width, d_x, d_y, d_width
  input  logic [((12*(COORD_INT_BITS+FRAC_BITS)+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // corner_a_x, corner_a_y, corner_b_x, corner_b_y,
  // corner_c_x, corner_c_y, corner_d_x, corner_d_y
  output logic [((8*(COORD_INT_BITS+FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
  // degenerate
  output logic m_axis_tuser,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata
);

  localparam int IN   = COORD_INT_BITS + FRAC_BITS;
  localparam int OUT  = IN + 2;
  localparam int LAST = EDGE_LAT + 7;
  localparam int M2W  = 17 + IN;
  localparam int M3W  = M2W + 5;
  localparam int UW   = M3W + 1 - UNIT_SHIFT - 2;
  localparam int VW   = UW + 2;
  localparam logic [M3W:0] RND = (M3W+1)'(((QUARTERS * MODULES) << UNIT_SHIFT) / 2);
  localparam logic [UW-1:0] RECIP7 = UW'((64'd1 << UW) / MODULES);
  localparam logic signed [VW-1:0] HI = VW'((64'sd1 <<< (OUT - 1)) - 1);
  localparam logic signed [VW-1:0] LO = -VW'(64'sd1 <<< (OUT - 1));

  logic [4:0] module_offset;
  logic adv;
  logic [LAST:0] vld;
  logic [12*IN-1:0] din [LAST];

  assign adv           = !vld[LAST] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      module_offset <= MO_RESET;
    end else if (cfg_we) begin
      module_offset <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      din[0] <= s_axis_tdata[12*IN-1:0];
      for (int k = 1; k < LAST; k++) begin
        din[k] <= din[k-1];
      end
    end
  end

  // Edge i runs from point i+1 toward point i.
  frbc_unit_t eu [4];
  for (genvar i = 0; i < 4; i++) begin : g_edge
    localparam int J = (i + 1) % 4;
    frbc_edge #(.IN_BITS(IN)) u_edge (
      .clk  (clk),
      .en   (adv),
      .a_x  (din[0][(3*i)*IN +: IN]),
      .a_y  (din[0][(3*i+1)*IN +: IN]),
      .b_x  (din[0][(3*J)*IN +: IN]),
      .b_y  (din[0][(3*J+1)*IN +: IN]),
      .unit (eu[i])
    );
  end

  // Axis a is point a/2, x for even a and y for odd a.
  logic signed [17:0] usum [8];
  always_comb begin
    for (int a = 0; a < 8; a++) begin
      if (a % 2 == 0) begin
        usum[a] = 18'(eu[a/2].ux) - 18'(eu[(a/2+3)%4].ux);
      end else begin
        usum[a] = 18'(eu[a/2].uy) - 18'(eu[(a/2+3)%4].uy);
      end
    end
  end

  logic [16:0]      mag1 [8];
  logic [M2W-1:0]   mag2 [8];
  logic [M3W-1:0]   mag3 [8];
  logic [UW-1:0]    u4   [8];
  logic [UW-1:0]    u5   [8];
  logic [2*UW-1:0]  prod5 [8];
  logic [UW-1:0]    off6 [8];
  logic [7:0]       neg1, neg2, neg3, neg4, neg5, neg6;
  logic [5:0]       deg_d;
  logic [OUT-1:0]   corner [8];
  logic             deg_out;

  logic [UW-1:0]    qe6 [8];
  logic [UW-1:0]    r6  [8];
  logic signed [VW-1:0] v7 [8];

  always_comb begin
    for (int a = 0; a < 8; a++) begin
      qe6[a] = UW'(prod5[a] >> UW);
      r6[a]  = u5[a] - UW'(qe6[a] * UW'(MODULES));
      v7[a]  = $signed(VW'(din[LAST-1][(3*(a/2)+(a%2))*IN +: IN]))
             + (neg6[a] ? -$signed(VW'(off6[a])) : $signed(VW'(off6[a])));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 8; a++) begin
        neg1[a] <= usum[a][17];
        mag1[a] <= usum[a][17] ? 17'(-usum[a]) : usum[a][16:0];
        mag2[a] <= M2W'(mag1[a]) * M2W'(din[EDGE_LAT+1][(3*(a/2)+2)*IN +: IN]);
        mag3[a] <= M3W'(mag2[a]) * M3W'(module_offset);
        // Rounded divide by 28 * 2^15: drop 15 + 2 bits, then divide by 7.
        u4[a]   <= UW'(((M3W+1)'(mag3[a]) + RND) >> (UNIT_SHIFT + 2));
        u5[a]   <= u4[a];
        prod5[a] <= (2*UW)'(u4[a]) * (2*UW)'(RECIP7);
        off6[a] <= (r6[a] >= UW'(MODULES)) ? qe6[a] + 1'b1 : qe6[a];
        if (v7[a] > HI) begin
          corner[a] <= HI[OUT-1:0];
        end else if (v7[a] < LO) begin
          corner[a] <= LO[OUT-1:0];
        end else begin
          corner[a] <= v7[a][OUT-1:0];
        end
      end
      neg2 <= neg1;
      neg3 <= neg2;
      neg4 <= neg3;
      neg5 <= neg4;
      neg6 <= neg5;
      deg_d   <= {deg_d[4:0], eu[0].deg | eu[1].deg | eu[2].deg | eu[3].deg};
      deg_out <= deg_d[5];
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    for (int a = 0; a < 8; a++) begin
      m_axis_tdata[a*OUT +: OUT] = corner[a];
    end
  end
  assign m_axis_tuser = deg_out;

  `FRBC_ASSERT_NEXT(a_accept_enters, clk, rst, s_axis_tvalid && s_axis_tready, vld[0], "accepted word did not enter the pipeline")
  `FRBC_ASSERT_NEXT(a_stall_holds, clk, rst, !adv, $stable(vld), "valid bits moved during a stall")
  `FRBC_ASSERT_NEXT(a_word_moves, clk, rst, vld[0] && adv, vld[1], "word lost between the first two stages")
  `FRBC_ASSERT_SAME(a_ready_free, clk, rst, !m_axis_tvalid, s_axis_tready, "input stalled with an empty output stage")

endmodule
